[hw/rtl/ccrf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccrf_pkg: shared types and tables of the chipset config register file
// Holds operation codes, register addresses, reset defaults, write masks and
// the command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package ccrf_pkg;

  // register file geometry (fixed by the 8-bit address field)
  localparam int unsigned REG_COUNT = 256;
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned TDATA_W   = 24;
  localparam int unsigned TUSER_W   = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 1;

  // operation carried with each input transaction
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_APM   = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  // configuration port indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_IDE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_FAST = 1'd1;

  // registers with side effects
  localparam logic [ADDR_W-1:0] ADDR_BUS_CTL = 8'h50;
  localparam logic [ADDR_W-1:0] ADDR_SMRAM   = 8'h70;
  localparam logic [ADDR_W-1:0] ADDR_SMI_CTL = 8'ha0;
  localparam logic [ADDR_W-1:0] ADDR_SMI_EN  = 8'ha2;
  localparam logic [ADDR_W-1:0] ADDR_FO_RELD = 8'ha8;
  localparam logic [ADDR_W-1:0] ADDR_SMI_STS = 8'haa;

  localparam logic [DATA_W-1:0] RD_NO_FUNC   = 8'hff;
  localparam logic [DATA_W-1:0] STS_APM_BIT  = 8'h80;
  localparam logic [DATA_W-1:0] STS_FO_BIT   = 8'h20;
  localparam logic [CNT_W-1:0]  FO_CNT_RESET = 9'd16;

  // controller to datapath commands
  typedef struct packed {
    logic              clear;
    logic [ADDR_W-1:0] clr_addr;
    logic              capture;
    logic              commit;
  } ccrf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } ccrf_status_t;

  // result of merging write data into a register
  typedef struct packed {
    logic              we;
    logic [DATA_W-1:0] val;
  } merge_t;

  // hard reset default of each register
  function automatic logic [DATA_W-1:0] reg_default(input logic [ADDR_W-1:0] addr);
    logic [DATA_W-1:0] v;
    unique case (addr)
      8'h00, 8'h02:                      v = 8'h86;
      8'h01, 8'h51, 8'h66, 8'h67:        v = 8'h80;
      8'h03:                             v = 8'h04;
      8'h04:                             v = 8'h07;
      8'h07, 8'h69:                      v = 8'h02;
      8'h4c:                             v = 8'h4d;
      8'h4e:                             v = 8'h03;
      8'h60, 8'h61, 8'h62, 8'h63, 8'h64: v = 8'h01;
      8'ha0:                             v = 8'h08;
      8'ha8:                             v = 8'h0f;
      default:                           v = 8'h00;
    endcase
    return v;
  endfunction

  // masked merge of a config write; SMRAM register handled separately,
  // reserved and read-only addresses come back with we clear
  function automatic merge_t reg_merge(input logic [ADDR_W-1:0] addr,
                                       input logic [DATA_W-1:0] old,
                                       input logic [DATA_W-1:0] data);
    merge_t m;
    m.we  = 1'b1;
    m.val = data;
    unique case (addr)
      8'h05:        m.val = data & 8'h01;
      8'h07:        m.val = old & ~(data & 8'hf0);
      8'h40, 8'h52: m.val = data & 8'h7f;
      8'h4c, 8'h51, 8'h57, 8'h68, 8'h69,
      8'h5a, 8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h5f,
      8'ha2, 8'ha5, 8'ha8, 8'hac, 8'hae:
                    m.val = data;
      8'h4d:        m.val = (old & 8'hef) | (data & 8'h10);
      8'h4e:        m.val = data & 8'hf7;
      8'h50:        m.val = data & 8'h0f;
      8'h53, 8'ha0: m.val = data & 8'h1f;
      8'h56:        m.val = data & 8'h3e;
      8'h59:        m.val = data & 8'hf0;
      8'h66, 8'h67: m.val = data & 8'h8f;
      8'ha4:        m.val = data & 8'hfb;
      8'ha7:        m.val = data & 8'he0;
      8'haa:        m.val = old & data;
      default:      m.we  = 1'b0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/ccrf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccrf_ctrl: sequencer of the chipset config register file
// Runs the clearing pass after reset, then steps each transaction through
// capture (register read) and commit (update and result load).
// ----------------------------------------------------------------------------
module ccrf_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  ccrf_pkg::ccrf_status_t status_i,
  output ccrf_pkg::ccrf_cmd_t  cmd_o
);
  import ccrf_pkg::*;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e            state_q;
  logic              ready_q;
  logic [ADDR_W-1:0] clr_q;
  logic              capture;
  logic              commit;

  // command decode
  assign capture = (state_q == ST_IDLE) && s_axis_tvalid;
  assign commit  = (state_q == ST_EXEC) && status_i.out_free;

  assign cmd_o.clear    = (state_q == ST_INIT);
  assign cmd_o.clr_addr = clr_q;
  assign cmd_o.capture  = capture;
  assign cmd_o.commit   = commit;
  assign s_axis_tready  = ready_q;

  // state and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      ready_q <= 1'b0;
      clr_q   <= '0;
    end else begin
      unique case (state_q)
        ST_INIT: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ADDR_W'(REG_COUNT - 1)) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (capture) begin
            state_q <= ST_EXEC;
            ready_q <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (commit) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_INIT;
          ready_q <= 1'b0;
        end
      endcase
    end
  end

  // no transaction taken while the clearing pass runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |-> !s_axis_tready)
    else $error("ready raised during clearing pass");

  // an accepted transaction blocks the next one until committed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |=> !s_axis_tready && !capture)
    else $error("second transaction taken before commit");

  // a commit reopens the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> s_axis_tready)
    else $error("input not reopened after commit");

endmodule
`default_nettype wire

[hw/rtl/ccrf_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ccrf_dp: datapath of the chipset config register file
// Register memory with masked read-modify-write, SMRAM lock and decode,
// APM and fast-off status, fast-off counter and the result register.
// ----------------------------------------------------------------------------
module ccrf_dp (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  ccrf_pkg::ccrf_cmd_t                cmd_i,
  output ccrf_pkg::ccrf_status_t             status_o,
  input  wire                                cfg_we_i,
  input  wire  [ccrf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [ccrf_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  input  wire  [ccrf_pkg::TDATA_W-1:0]       s_axis_tdata,
  input  wire  [ccrf_pkg::TUSER_W-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [ccrf_pkg::TDATA_W-1:0]       m_axis_tdata
);
  import ccrf_pkg::*;

  // register memory
  logic [DATA_W-1:0] mem [REG_COUNT];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] rd_addr;

  // captured transaction
  op_e               op_q;
  logic [2:0]        fn_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;
  op_e               op_in;

  // architectural side state
  logic [DATA_W-1:0] r70_q, r70_d;
  logic              lock_q, lock_d;
  logic              a0b0_q, a0b0_d;
  logic              a2b7_q, a2b7_d;
  logic [DATA_W-1:0] a8_q, a8_d;
  logic              b50_q, b50_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  // update results
  logic              wr_en;
  logic [DATA_W-1:0] wr_val;
  logic [ADDR_W-1:0] wr_addr;
  logic              fn_zero;
  merge_t            merge;
  logic [DATA_W-1:0] rd_byte;
  logic [DATA_W-1:0] read_data;
  logic              smi;
  logic              apm_en_cur;
  logic              apm_en_nxt;
  logic [2:0]        sel;
  logic              en;
  logic [3:0]        host_blk;
  logic [3:0]        ram_blk;
  logic              out_valid_q;
  logic [TDATA_W-1:0] out_data_q;

  assign op_in      = op_e'(s_axis_tuser);
  assign rd_addr    = (op_in == OP_APM || op_in == OP_TICK) ? ADDR_SMI_STS
                                                            : s_axis_tdata[10:3];
  assign fn_zero    = (fn_q == 3'd0);
  assign apm_en_cur = a0b0_q && a2b7_q;
  assign wr_addr    = (op_q == OP_WRITE) ? addr_q : ADDR_SMI_STS;
  assign merge      = reg_merge(addr_q, rdata_q, wdata_q);

  // per-operation update
  always_comb begin
    wr_en  = 1'b0;
    wr_val = rdata_q;
    r70_d  = r70_q;
    lock_d = lock_q;
    a0b0_d = a0b0_q;
    a2b7_d = a2b7_q;
    a8_d   = a8_q;
    b50_d  = b50_q;
    cnt_d  = cnt_q;
    smi    = 1'b0;
    unique case (op_q)
      OP_READ: begin
      end
      OP_WRITE: begin
        if (fn_zero) begin
          if (addr_q == ADDR_SMRAM) begin
            wr_en = 1'b1;
            if (lock_q) begin
              r70_d = (r70_q & 8'hdf) | (wdata_q & 8'h20);
            end else begin
              r70_d  = (r70_q & 8'h88) | (wdata_q & 8'h77);
              lock_d = wdata_q[4];
              if (wdata_q[4]) begin
                r70_d = r70_d & 8'hbf;
              end
            end
            wr_val = r70_d;
          end else begin
            wr_en  = merge.we;
            wr_val = merge.val;
            if (addr_q == ADDR_SMI_CTL) begin
              a0b0_d = wdata_q[0];
              cnt_d  = {1'b0, a8_q} + CNT_W'(1);
            end
            if (addr_q == ADDR_SMI_EN) begin
              a2b7_d = wdata_q[7];
            end
            if (addr_q == ADDR_FO_RELD) begin
              a8_d  = wdata_q;
              cnt_d = {1'b0, wdata_q} + CNT_W'(1);
            end
            if (addr_q == ADDR_BUS_CTL) begin
              b50_d = wdata_q[1];
            end
          end
        end
      end
      OP_APM: begin
        if (apm_en_cur) begin
          wr_en  = 1'b1;
          wr_val = rdata_q | STS_APM_BIT;
        end
      end
      OP_TICK: begin
        wr_en  = 1'b1;
        wr_val = rdata_q | STS_FO_BIT;
        cnt_d  = cnt_q - CNT_W'(1);
        smi    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // memory write port: clearing pass or commit
  assign mem_we    = cmd_i.clear || (cmd_i.commit && wr_en);
  assign mem_waddr = cmd_i.clear ? cmd_i.clr_addr : wr_addr;
  assign mem_wdata = cmd_i.clear ? reg_default(cmd_i.clr_addr) : wr_val;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.capture) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_in;
      fn_q    <= s_axis_tdata[2:0];
      addr_q  <= s_axis_tdata[10:3];
      wdata_q <= s_axis_tdata[18:11];
    end
  end

  // side state, bus speed strap from the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r70_q  <= '0;
      lock_q <= 1'b0;
      a0b0_q <= 1'b0;
      a2b7_q <= 1'b0;
      a8_q   <= 8'h0f;
      b50_q  <= 1'b0;
      cnt_q  <= FO_CNT_RESET;
    end else begin
      if (cmd_i.commit) begin
        r70_q  <= r70_d;
        lock_q <= lock_d;
        a0b0_q <= a0b0_d;
        a2b7_q <= a2b7_d;
        a8_q   <= a8_d;
        b50_q  <= b50_d;
        cnt_q  <= cnt_d;
      end else if (cfg_we_i && cfg_idx_i == CFG_BUS_FAST) begin
        b50_q <= cfg_data_i[0];
      end
    end
  end

  // read data, bus speed bit kept outside the memory
  always_comb begin
    rd_byte = rdata_q;
    if (addr_q == ADDR_BUS_CTL) begin
      rd_byte[1] = b50_q;
    end
    read_data = '0;
    if (op_q == OP_READ) begin
      read_data = fn_zero ? rd_byte : RD_NO_FUNC;
    end
  end

  // SMRAM decode and APM enable after the update
  assign apm_en_nxt = a0b0_d && a2b7_d;
  assign sel        = r70_d[2:0];
  assign en         = (sel >= 3'd2);
  assign host_blk   = en ? {1'b1, sel} : 4'h0;
  assign ram_blk    = en ? ((sel == 3'd3) ? 4'hb : 4'ha) : 4'h0;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {3'b000, !r70_d[5], (r70_d[6:4] == 3'b100), ram_blk, host_blk,
                     en, apm_en_nxt, smi, read_data};
    end
  end

  assign m_axis_tvalid     = out_valid_q;
  assign m_axis_tdata      = out_data_q;
  assign status_o.out_free = !out_valid_q || m_axis_tready;

  // a commit never overwrites a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && !m_axis_tready))
    else $error("result overwritten before transfer");

  // SMRAM lock is sticky until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q |=> lock_q)
    else $error("SMRAM lock dropped");

  // a fast-off tick always reports an SMI
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && op_q == OP_TICK) |=> (m_axis_tvalid && m_axis_tdata[8]))
    else $error("fast-off tick without SMI");

endmodule
`default_nettype wire

[hw/rtl/chipset_config_register_file.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chipset_config_register_file: 256-byte bridge configuration space
// Masked register writes, SMRAM lock and window decode, APM and fast-off
// SMI status, one result per transaction.
//
//   channel   direction  signals                        contents
//   s_axis    in         tvalid tready tdata tuser      one operation
//   m_axis    out        tvalid tready tdata            one result
//   cfg       in         cfg_we_i cfg_idx_i cfg_data_i  strap registers
//
// Each transaction is first captured, with a read of the register memory
// (registered read port), then merged, written back and loaded into the
// result register.
// After reset a clearing pass loads the default values into the memory;
// s_axis_tready stays low until it ends.
// A full result register holds the transaction in its commit step until
// m_axis_tready frees it; a waiting result does not block capture.
// ----------------------------------------------------------------------------
module chipset_config_register_file (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration port
  input  wire                                cfg_we_i,
  input  wire  [ccrf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [ccrf_pkg::CFG_DAT_W-1:0]     cfg_data_i,
  // input transactions
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // pci_function[2:0], reg_addr[10:3], write_data[18:11], zero fill
  input  wire  [ccrf_pkg::TDATA_W-1:0]       s_axis_tdata,
  // func[1:0]
  input  wire  [ccrf_pkg::TUSER_W-1:0]       s_axis_tuser,
  // results
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // read_data[7:0], smi_pulse[8], apm_smi_enable[9], smram_enabled[10],
  // smram_host_block[14:11], smram_ram_block[18:15], smram_open_flag[19],
  // smram_not_closed[20], zero fill
  output logic [ccrf_pkg::TDATA_W-1:0]       m_axis_tdata
);
  import ccrf_pkg::*;

  ccrf_cmd_t    cmd;
  ccrf_status_t status;

  // sequencer
  ccrf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // register memory and decode
  ccrf_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire
